FILE: src/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

    localparam int BOOK_DEPTH      = 32;
    localparam int PRICE_FRAC_BITS = 8;

    localparam int PRICE_W = 20;
    localparam int QTY_W   = 24;
    localparam int TIME_W  = 32;
    localparam int IDENT_W = 32;
    localparam int FP_W    = 28;
    localparam int IDX_W   = $clog2(BOOK_DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int SUM_W   = PRICE_W + QTY_W;
    localparam int DIVD_W  = SUM_W + PRICE_FRAC_BITS;
    localparam int QUO_W   = PRICE_W + PRICE_FRAC_BITS;
    localparam int DCNT_W  = $clog2(QUO_W + 1);

    localparam logic       SIDE_BID    = 1'b0;
    localparam logic       KIND_MARKET = 1'b1;
    localparam logic [1:0] TERM_OTHER  = 2'd2;

    localparam logic [1:0] ST_PARTIAL = 2'd0;
    localparam logic [1:0] ST_FILLED  = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    typedef struct packed {
        logic               side;
        logic               order_kind;
        logic [1:0]         term;
        logic [PRICE_W-1:0] limit_price;
        logic [QTY_W-1:0]   quantity;
        logic [IDENT_W-1:0] order_ident;
        logic [TIME_W-1:0]  arrival_time;
        logic               own_order;
    } lobm_in_t;

    typedef struct packed {
        logic [FP_W-1:0]    fill_price;
        logic [QTY_W-1:0]   filled_qty;
        logic [1:0]         fill_status;
        logic [IDENT_W-1:0] report_ident;
        logic               reroute;
        logic               last_record;
    } lobm_out_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [TIME_W-1:0]  time_key;
        logic [IDENT_W-1:0] ident;
        logic               own;
    } lobm_entry_t;

endpackage

FILE: src/limit_order_book_matcher_unit.sv
// Price-time priority order matcher: both books in one memory, swept by a sequencer.
//
//  channel | ports             | payload              | direction
//  --------+-------------------+----------------------+----------
//  orders  | s_valid / s_ready | s_data (lobm_in_t)   | in
//  records | m_valid / m_ready | m_data (lobm_out_t)  | out
//
// One order at a time, s_ready only in idle. Each resting order swept is read, compared
// and updated, plus an emit per own fill record; the first read and compare double as the
// cross check. Insert: setup, a read and a write per shifted entry, the new entry's write.
// Average price: setup, 28 quotient bits unless nothing filled, the final record. Book
// memory has one read and one write port. Reset clears only state, m_valid, counts and
// head pointers. A stalled result channel holds the sequencer at its next record transfer.
module limit_order_book_matcher_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lobm_pkg::lobm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lobm_pkg::lobm_out_t m_data
);
    import lobm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_EVAL     = 4'd2;
    localparam logic [3:0] S_ACC      = 4'd3;
    localparam logic [3:0] S_EMIT     = 4'd4;
    localparam logic [3:0] S_INS      = 4'd5;
    localparam logic [3:0] S_INS_RD   = 4'd6;
    localparam logic [3:0] S_INS_CMP  = 4'd7;
    localparam logic [3:0] S_DIV_INIT = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    localparam int ADDR_W = IDX_W + 1;
    localparam int MEM_D  = 2 * BOOK_DEPTH;

    // both books share one memory: address = {side, slot}
    lobm_entry_t book_mem [MEM_D];
    lobm_entry_t rd_reg;

    logic [3:0]         state_reg, state_next;
    lobm_in_t           ord_reg, ord_next;
    logic [QTY_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   prod_reg, prod_next;
    logic               first_reg, first_next;
    logic               nocross_reg, nocross_next;
    logic [1:0]         status_reg, status_next;
    lobm_out_t          rec_reg, rec_next;
    logic [CNT_W-1:0]   count_reg [2];
    logic [CNT_W-1:0]   count_next [2];
    logic [IDX_W-1:0]   head_reg [2];
    logic [IDX_W-1:0]   head_next [2];
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [QTY_W-1:0]   dr_reg, dr_next;
    logic [QUO_W-1:0]   dq_reg, dq_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic               m_valid_reg, m_valid_next;
    lobm_out_t          m_data_reg, m_data_next;

    logic               mem_re, mem_we;
    logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
    lobm_entry_t        mem_wdata;

    logic               opp;
    logic               market;
    logic               crosses;
    logic               full_take;
    logic [QTY_W-1:0]   take;
    logic               need_ins;
    logic [QTY_W-1:0]   filled;
    logic [DIVD_W-1:0]  dividend;
    logic [QTY_W:0]     trial;
    logic               out_free;
    logic [IDX_W-1:0]   own_slot;
    lobm_entry_t        new_entry;

    // true if entry a ranks strictly ahead of entry b in the book of side s
    function automatic logic ranks_ahead(input logic s, input lobm_entry_t a,
                                         input lobm_entry_t b);
        if (a.price != b.price) begin
            return (s == SIDE_BID) ? (a.price > b.price) : (a.price < b.price);
        end
        return a.time_key < b.time_key;
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign opp      = ~ord_reg.side;
    assign market   = (ord_reg.order_kind == KIND_MARKET);
    assign crosses  = market || ((ord_reg.side == SIDE_BID) ?
                      (ord_reg.limit_price >= rd_reg.price) :
                      (ord_reg.limit_price <= rd_reg.price));
    assign full_take = (rem_reg >= rd_reg.qty);
    assign take      = full_take ? rd_reg.qty : rem_reg;
    assign need_ins  = !market && (nocross_reg || (rem_reg != '0));
    assign filled    = ord_reg.quantity - rem_reg;
    assign dividend  = {sum_reg, {PRICE_FRAC_BITS{1'b0}}};
    assign trial     = {dr_reg, dq_reg[QUO_W-1]};
    assign out_free  = !m_valid_reg || m_ready;
    assign own_slot  = head_reg[ord_reg.side] + idx_reg[IDX_W-1:0];

    always_comb begin
        new_entry          = '0;
        new_entry.price    = ord_reg.limit_price;
        new_entry.qty      = rem_reg;
        new_entry.time_key = ord_reg.arrival_time;
        new_entry.ident    = ord_reg.order_ident;
        new_entry.own      = ord_reg.own_order;
    end

    always_comb begin
        state_next   = state_reg;
        ord_next     = ord_reg;
        rem_next     = rem_reg;
        sum_next     = sum_reg;
        prod_next    = prod_reg;
        first_next   = first_reg;
        nocross_next = nocross_reg;
        status_next  = status_reg;
        rec_next     = rec_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        idx_next     = idx_reg;
        dr_next      = dr_reg;
        dq_next      = dq_reg;
        dcnt_next    = dcnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = {opp, head_reg[opp]};
        mem_we       = 1'b0;
        mem_waddr    = {opp, head_reg[opp]};
        mem_wdata    = rd_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ord_next     = s_data;
                    rem_next     = s_data.quantity;
                    sum_next     = '0;
                    first_next   = 1'b1;
                    nocross_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (count_reg[opp] == '0) begin
                    nocross_next = first_reg;
                    state_next   = S_INS;
                end else if (!first_reg && (rem_reg == '0)) begin
                    state_next = S_INS;
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!crosses) begin
                    nocross_next = first_reg;
                    state_next   = S_INS;
                end else if (first_reg && (ord_reg.term >= TERM_OTHER)) begin
                    state_next = S_IDLE;
                end else if (rem_reg == '0) begin
                    // zero-quantity crossing order: nothing is swept
                    first_next = 1'b0;
                    state_next = S_INS;
                end else begin
                    first_next = 1'b0;
                    prod_next  = SUM_W'(rd_reg.price) * SUM_W'(take);
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                sum_next              = sum_reg + prod_reg;
                rec_next.fill_price   = FP_W'(rd_reg.price) << PRICE_FRAC_BITS;
                rec_next.filled_qty   = take;
                rec_next.report_ident = rd_reg.ident;
                rec_next.reroute      = 1'b0;
                rec_next.last_record  = 1'b0;
                if (full_take) begin
                    rec_next.fill_status = ST_FILLED;
                    head_next[opp]  = head_reg[opp] + 1'b1;
                    count_next[opp] = count_reg[opp] - 1'b1;
                    rem_next        = rem_reg - rd_reg.qty;
                end else begin
                    rec_next.fill_status = ST_PARTIAL;
                    mem_we        = 1'b1;
                    mem_wdata.qty = rd_reg.qty - rem_reg;
                    rem_next      = '0;
                end
                state_next = rd_reg.own ? S_EMIT : S_CHECK;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rec_reg;
                    state_next   = S_CHECK;
                end
            end
            S_INS: begin
                status_next = (!nocross_reg && (rem_reg == '0)) ? ST_FILLED : ST_PARTIAL;
                idx_next    = count_reg[ord_reg.side];
                if (!need_ins) begin
                    state_next = S_DIV_INIT;
                end else if (count_reg[ord_reg.side] == CNT_W'(BOOK_DEPTH)) begin
                    status_next = ST_REJECT;
                    state_next  = S_DIV_INIT;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = {ord_reg.side, own_slot};
                    mem_wdata  = new_entry;
                    count_next[ord_reg.side] = count_reg[ord_reg.side] + 1'b1;
                    state_next = S_DIV_INIT;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = {ord_reg.side, own_slot - 1'b1};
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = {ord_reg.side, own_slot};
                if (ranks_ahead(ord_reg.side, rd_reg, new_entry)) begin
                    mem_wdata  = new_entry;
                    count_next[ord_reg.side] = count_reg[ord_reg.side] + 1'b1;
                    state_next = S_DIV_INIT;
                end else begin
                    mem_wdata  = rd_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_INS_RD;
                end
            end
            S_DIV_INIT: begin
                dcnt_next = '0;
                if (filled == '0) begin
                    dq_next    = '0;
                    state_next = S_FIN;
                end else begin
                    dr_next    = dividend[DIVD_W-1:QUO_W];
                    dq_next    = dividend[QUO_W-1:0];
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (trial >= {1'b0, filled}) begin
                    dr_next = QTY_W'(trial - {1'b0, filled});
                    dq_next = {dq_reg[QUO_W-2:0], 1'b1};
                end else begin
                    dr_next = trial[QTY_W-1:0];
                    dq_next = {dq_reg[QUO_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(QUO_W - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!ord_reg.own_order) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.fill_price   = FP_W'(dq_reg);
                    m_data_next.filled_qty   = filled;
                    m_data_next.fill_status  = status_reg;
                    m_data_next.report_ident = ord_reg.order_ident;
                    m_data_next.reroute      = market && (nocross_reg || (rem_reg != '0));
                    m_data_next.last_record  = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            book_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= book_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        ord_reg     <= ord_next;
        rem_reg     <= rem_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        first_reg   <= first_next;
        nocross_reg <= nocross_next;
        status_reg  <= status_next;
        rec_reg     <= rec_next;
        idx_reg     <= idx_next;
        dr_reg      <= dr_next;
        dq_reg      <= dq_next;
        dcnt_reg    <= dcnt_next;
        m_data_reg  <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= CNT_W'(BOOK_DEPTH)) && (count_reg[1] <= CNT_W'(BOOK_DEPTH)))
        else $error("book count above depth");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_data_reg))
        else $error("pending record overwritten");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (filled != '0))
        else $error("division by zero fill");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (state_reg == S_CHECK))
        else $error("accepted order not started");
`endif

endmodule
